@@ rtl/ahf_pkg.sv @@
// Shared types and fixed widths for the adaptive Huffman (FGK) coder.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package ahf_pkg;

  localparam int SYM_W    = 8;
  localparam int WEIGHT_W = 32;
  localparam int CODE_W   = 32;
  localparam int COUNT_W  = 6;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LEAF,
    OP_WALK_P,
    OP_WALK_L,
    OP_WALK_B,
    OP_EMIT_RD,
    OP_EMIT_SH,
    OP_OUT,
    OP_UPD,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_TOP,
    OP_RDN,
    OP_GETN,
    OP_SCAN,
    OP_X1,
    OP_X2,
    OP_X3,
    OP_X4,
    OP_XW1,
    OP_XW2,
    OP_INC,
    OP_NXT
  } dp_op_t;

  typedef struct packed {
    logic start_zero;
    logic p_zero;
    logic par_zero;
    logic n_zero;
    logic more_bits;
    logic last;
    logic out_free;
    logic skip_upd;
    logic present;
    logic split_ok;
    logic scan_done;
    logic found;
  } dp_status_t;

endpackage

@@ rtl/ahf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ahf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ahf_ctrl.sv @@
// Sequencer for the FGK coder: code walk, chunk emission and tree update.
// Depends on ahf_pkg for the command and status types.
`timescale 1ns / 1ps
module ahf_ctrl import ahf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_op_t     op
);

  typedef enum logic [4:0] {
    S_IDLE, S_LEAF, S_WALK_P, S_WALK_L, S_WALK_B, S_EMIT_RD, S_EMIT_SH, S_OUT,
    S_UPD, S_SPLIT1, S_SPLIT2, S_TOP, S_RDN, S_GETN, S_SCAN,
    S_X1, S_X2, S_X3, S_X4, S_XW1, S_XW2, S_INC, S_NXT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        op = OP_IDLE;
        if (in_valid) state_nxt = S_LEAF;
      end
      S_LEAF: begin
        op = OP_LEAF;
        state_nxt = st.start_zero ? S_EMIT_RD : S_WALK_P;
      end
      S_WALK_P: begin
        op = OP_WALK_P;
        state_nxt = S_WALK_L;
      end
      S_WALK_L: begin
        op = OP_WALK_L;
        state_nxt = S_WALK_B;
      end
      S_WALK_B: begin
        op = OP_WALK_B;
        state_nxt = st.p_zero ? S_EMIT_RD : S_WALK_P;
      end
      S_EMIT_RD: begin
        op = OP_EMIT_RD;
        state_nxt = st.more_bits ? S_EMIT_SH : S_OUT;
      end
      S_EMIT_SH: begin
        op = OP_EMIT_SH;
        state_nxt = S_EMIT_RD;
      end
      S_OUT: begin
        op = OP_OUT;
        if (st.out_free) state_nxt = st.last ? S_UPD : S_EMIT_RD;
      end
      S_UPD: begin
        op = OP_UPD;
        if (st.skip_upd) state_nxt = S_IDLE;
        else if (st.present) state_nxt = S_TOP;
        else if (st.split_ok) state_nxt = S_SPLIT1;
        else state_nxt = S_IDLE;
      end
      S_SPLIT1: begin
        op = OP_SPLIT1;
        state_nxt = S_SPLIT2;
      end
      S_SPLIT2: begin
        op = OP_SPLIT2;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        op = OP_TOP;
        state_nxt = st.n_zero ? S_IDLE : S_RDN;
      end
      S_RDN: begin
        op = OP_RDN;
        state_nxt = S_GETN;
      end
      S_GETN: begin
        op = OP_GETN;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (st.scan_done) state_nxt = st.found ? S_X1 : S_INC;
      end
      S_X1: begin
        op = OP_X1;
        state_nxt = S_X2;
      end
      S_X2: begin
        op = OP_X2;
        state_nxt = S_X3;
      end
      S_X3: begin
        op = OP_X3;
        state_nxt = S_X4;
      end
      S_X4: begin
        op = OP_X4;
        state_nxt = S_XW1;
      end
      S_XW1: begin
        op = OP_XW1;
        state_nxt = S_XW2;
      end
      S_XW2: begin
        op = OP_XW2;
        state_nxt = S_INC;
      end
      S_INC: begin
        op = OP_INC;
        state_nxt = S_NXT;
      end
      S_NXT: begin
        op = OP_NXT;
        state_nxt = st.par_zero ? S_IDLE : S_RDN;
      end
      default: begin
        op = OP_IDLE;
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ahf_dp.sv @@
// Datapath for the FGK coder: node tables, path store, scan and output register.
// Depends on ahf_pkg and ahf_ram.
`timescale 1ns / 1ps
module ahf_dp import ahf_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int TOP_ORDER     = 512,
  parameter int CHUNK_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_op_t              op,
  output dp_status_t          st,
  input  logic                in_valid,
  input  logic [SYM_W-1:0]    in_symbol,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   out_code_bits,
  output logic [COUNT_W-1:0]  out_bit_count,
  output logic                out_is_new,
  output logic                out_weight_full,
  output logic                out_last
);

  localparam int NODE_CAP = 2 * ALPHABET_SIZE;
  localparam int NW       = $clog2(NODE_CAP);
  localparam int UW       = $clog2(NODE_CAP + 1);
  localparam int OW       = $clog2(TOP_ORDER + 1);
  localparam int SW       = $clog2(ALPHABET_SIZE);
  localparam int CNTW     = $clog2(CHUNK_BITS + 1);

  logic [NW-1:0] par_rd, lc_rd, rc_rd, leaf_rd;
  logic [WEIGHT_W-1:0] wt_rd;
  logic [OW-1:0] ord_rd;
  logic path_rd;

  logic par_we, lc_we, rc_we, wt_we, ord_we, leaf_we, path_we;
  logic [NW-1:0] par_wa, lc_wa, rc_wa, wt_wa, ord_wa, path_wa;
  logic [NW-1:0] par_wd, lc_wd, rc_wd;
  logic [WEIGHT_W-1:0] wt_wd;
  logic [OW-1:0] ord_wd;
  logic path_wd;
  logic [NW-1:0] par_ra, lc_ra, wt_ra, path_ra;

  logic [SYM_W-1:0] sym_r;
  logic valid_r, present_r, full_r;
  logic [NW-1:0] start_r, n_r, p_r, best_r, pa_r, pb_r, lca_r, rca_r, lcb_r, id_r, nyt_r;
  logic [NW-1:0] pn_r;
  logic [UW-1:0] len_r, pos_r, i_r, used_r;
  logic [CNTW-1:0] cnt_r;
  logic [CHUNK_BITS-1:0] chunk_r;
  logic [WEIGHT_W-1:0] wn_r, root_w_r;
  logic [OW-1:0] on_r, best_ord_r, nyt_ord_r;
  logic sv_r, found_r;
  logic [ALPHABET_SIZE-1:0] pres_r;
  logic out_valid_r, out_is_new_r, out_full_r, out_last_r;
  logic [CODE_W-1:0] out_code_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [SW-1:0] in_idx, sym_idx;
  logic in_ok, out_take, out_free, last_bit, same_par, cand;
  logic [NW-1:0] start_val, nn, leaf_n;
  logic [UW-1:0] path_pos;

  assign in_idx    = in_symbol[SW-1:0];
  assign sym_idx   = sym_r[SW-1:0];
  assign in_ok     = ({1'b0, in_symbol} < (SYM_W + 1)'(ALPHABET_SIZE));
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || out_take;
  assign last_bit  = (pos_r >= len_r);
  assign start_val = present_r ? leaf_rd : nyt_r;
  assign nn        = used_r[NW-1:0];
  assign leaf_n    = nn + NW'(1);
  assign same_par  = (pa_r == pb_r);
  assign path_pos  = len_r - UW'(1) - pos_r;
  // only the parent can be an ancestor of equal weight (when the sibling is the NYT)
  assign cand = sv_r && (id_r != n_r) && (id_r != pn_r) && (wt_rd == wn_r) &&
                (ord_rd > on_r) && (!found_r || ord_rd > best_ord_r);

  always_comb begin
    st.start_zero = (start_val == '0);
    st.p_zero     = (p_r == '0);
    st.par_zero   = (par_rd == '0);
    st.n_zero     = (n_r == '0);
    st.more_bits  = (pos_r < len_r) && (cnt_r < CNTW'(CHUNK_BITS));
    st.last       = last_bit;
    st.out_free   = out_free;
    st.skip_upd   = full_r || !valid_r;
    st.present    = present_r;
    st.split_ok   = (({1'b0, used_r} + (UW + 1)'(2)) <= (UW + 1)'(NODE_CAP)) &&
                    (nyt_ord_r >= OW'(2));
    st.scan_done  = (i_r >= used_r) && !sv_r;
    st.found      = found_r;
  end

  always_comb begin
    case (op)
      OP_X2:           par_ra = best_r;
      default:         par_ra = n_r;
    endcase
    case (op)
      OP_WALK_L: lc_ra = par_rd;
      OP_X4:     lc_ra = pb_r;
      default:   lc_ra = pa_r;
    endcase
    wt_ra   = (op == OP_SCAN) ? i_r[NW-1:0] : n_r;
    path_ra = path_pos[NW-1:0];
  end

  always_comb begin
    par_we = 1'b0; par_wa = n_r; par_wd = pb_r;
    lc_we  = 1'b0; lc_wa  = pa_r; lc_wd = best_r;
    rc_we  = 1'b0; rc_wa  = pa_r; rc_wd = best_r;
    wt_we  = 1'b0; wt_wa  = n_r; wt_wd = wn_r + WEIGHT_W'(1);
    ord_we = 1'b0; ord_wa = n_r; ord_wd = best_ord_r;
    leaf_we = 1'b0;
    path_we = (op == OP_WALK_B);
    path_wa = len_r[NW-1:0];
    path_wd = (lc_rd != n_r);
    case (op)
      OP_SPLIT1: begin
        par_we = 1'b1; par_wa = nn; par_wd = n_r;
        wt_we = 1'b1; wt_wa = nn; wt_wd = '0;
        ord_we = 1'b1; ord_wa = nn; ord_wd = nyt_ord_r - OW'(2);
        lc_we = 1'b1; lc_wa = n_r; lc_wd = nn;
        rc_we = 1'b1; rc_wa = n_r; rc_wd = leaf_n;
        leaf_we = 1'b1;
      end
      OP_SPLIT2: begin
        par_we = 1'b1; par_wa = leaf_n; par_wd = n_r;
        wt_we = 1'b1; wt_wa = leaf_n; wt_wd = WEIGHT_W'(1);
        ord_we = 1'b1; ord_wa = leaf_n; ord_wd = nyt_ord_r - OW'(1);
      end
      OP_XW1: begin
        ord_we = 1'b1; ord_wa = n_r; ord_wd = best_ord_r;
        if (same_par) begin
          lc_we = 1'b1; lc_wd = rca_r;
          rc_we = 1'b1; rc_wd = lca_r;
        end else begin
          lc_we = (lca_r == n_r);
          rc_we = (lca_r != n_r);
          par_we = 1'b1; par_wa = n_r; par_wd = pb_r;
        end
      end
      OP_XW2: begin
        ord_we = 1'b1; ord_wa = best_r; ord_wd = on_r;
        if (!same_par) begin
          lc_wa = pb_r; lc_wd = n_r; lc_we = (lcb_r == best_r);
          rc_wa = pb_r; rc_wd = n_r; rc_we = (lcb_r != best_r);
          par_we = 1'b1; par_wa = best_r; par_wd = pa_r;
        end
      end
      OP_INC: wt_we = 1'b1;
      default: ;
    endcase
  end

  ahf_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_par (
    .clk, .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
  ahf_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_lc (
    .clk, .we(lc_we), .waddr(lc_wa), .wdata(lc_wd), .raddr(lc_ra), .rdata(lc_rd));
  ahf_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_rc (
    .clk, .we(rc_we), .waddr(rc_wa), .wdata(rc_wd), .raddr(pa_r), .rdata(rc_rd));
  ahf_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODE_CAP)) u_wt (
    .clk, .we(wt_we), .waddr(wt_wa), .wdata(wt_wd), .raddr(wt_ra), .rdata(wt_rd));
  ahf_ram #(.WIDTH(OW), .DEPTH(NODE_CAP)) u_ord (
    .clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(wt_ra), .rdata(ord_rd));
  ahf_ram #(.WIDTH(NW), .DEPTH(ALPHABET_SIZE)) u_leaf (
    .clk, .we(leaf_we), .waddr(sym_idx), .wdata(leaf_n), .raddr(in_idx), .rdata(leaf_rd));
  ahf_ram #(.WIDTH(1), .DEPTH(NODE_CAP)) u_path (
    .clk, .we(path_we), .waddr(path_wa), .wdata(path_wd), .raddr(path_ra), .rdata(path_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nyt_r       <= '0;
      nyt_ord_r   <= OW'(TOP_ORDER);
      used_r      <= UW'(1);
      root_w_r    <= '0;
      pres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take && op != OP_OUT) out_valid_r <= 1'b0;
      case (op)
        OP_IDLE: if (in_valid) begin
          sym_r     <= in_symbol;
          valid_r   <= in_ok;
          present_r <= in_ok && pres_r[in_idx];
          full_r    <= &root_w_r;
        end
        OP_LEAF: begin
          start_r <= start_val;
          n_r     <= start_val;
          len_r   <= '0;
          pos_r   <= '0;
          cnt_r   <= '0;
          chunk_r <= '0;
        end
        OP_WALK_L: p_r <= par_rd;
        OP_WALK_B: begin
          len_r <= len_r + UW'(1);
          n_r   <= p_r;
        end
        OP_EMIT_SH: begin
          chunk_r <= (chunk_r << 1) | CHUNK_BITS'(path_rd);
          pos_r   <= pos_r + UW'(1);
          cnt_r   <= cnt_r + CNTW'(1);
        end
        OP_OUT: if (out_free) begin
          out_valid_r  <= 1'b1;
          out_code_r   <= CODE_W'(chunk_r);
          out_count_r  <= COUNT_W'(cnt_r);
          out_is_new_r <= !present_r;
          out_full_r   <= full_r;
          out_last_r   <= last_bit;
          chunk_r      <= '0;
          cnt_r        <= '0;
        end
        OP_UPD: n_r <= present_r ? start_r : nyt_r;
        OP_SPLIT1: pres_r[sym_idx] <= 1'b1;
        OP_SPLIT2: begin
          nyt_r     <= nn;
          nyt_ord_r <= nyt_ord_r - OW'(2);
          used_r    <= used_r + UW'(2);
        end
        OP_TOP: if (n_r == '0) root_w_r <= root_w_r + WEIGHT_W'(1);
        OP_RDN: begin
          i_r     <= UW'(1);
          sv_r    <= 1'b0;
          found_r <= 1'b0;
        end
        OP_GETN: begin
          wn_r <= wt_rd;
          on_r <= ord_rd;
          pn_r <= par_rd;
        end
        OP_SCAN: begin
          if (cand) begin
            best_r     <= id_r;
            best_ord_r <= ord_rd;
            found_r    <= 1'b1;
          end
          if (i_r < used_r) begin
            id_r <= i_r[NW-1:0];
            i_r  <= i_r + UW'(1);
            sv_r <= 1'b1;
          end else begin
            sv_r <= 1'b0;
          end
        end
        OP_X2: pa_r <= par_rd;
        OP_X3: pb_r <= par_rd;
        OP_X4: begin
          lca_r <= lc_rd;
          rca_r <= rc_rd;
        end
        OP_XW1: lcb_r <= lc_rd;
        OP_NXT: begin
          n_r <= par_rd;
          if (par_rd == '0) root_w_r <= root_w_r + WEIGHT_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_bits   = out_code_r;
  assign out_bit_count   = out_count_r;
  assign out_is_new      = out_is_new_r;
  assign out_weight_full = out_full_r;
  assign out_last        = out_last_r;

endmodule

@@ rtl/adaptive_huffman_fgk_coder.sv @@
// Top level of the adaptive Huffman (FGK) coder: controller plus datapath.
// Depends on ahf_pkg, ahf_ctrl, ahf_dp and ahf_ram.
`timescale 1ns / 1ps
// One symbol is taken at a time; in_stall stays high until the tree update of the
// previous symbol has finished. After the accepting cycle, a symbol walks its path
// out of the parent and child tables (one registered read per table access), then
// emits its bits into chunks; a stalled chunk holds the sequencer until the output
// register frees. The FGK update then starts (an unseen symbol first splits the NYT
// node), and for each node on the climb below the root scans the weight and order
// tables over the nodes in use at one node per cycle, then does the swap (states X1
// to X4, XW1 and XW2) when one is found, so the update time grows with the nodes in
// use. The final chunk of a symbol may wait in the output register while the update
// runs. No clearing pass runs after reset: only the root weight, the NYT pointer and
// order, the node count, one presence bit per symbol and the output valid flag are
// reset.
module adaptive_huffman_fgk_coder import ahf_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int TOP_ORDER     = 512,
  parameter int CHUNK_BITS    = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SYM_W-1:0]   in_symbol,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CODE_W-1:0]  out_code_bits,
  output logic [COUNT_W-1:0] out_bit_count,
  output logic               out_is_new,
  output logic               out_weight_full,
  output logic               out_last
);

  dp_op_t     op;
  dp_status_t st;

  ahf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .st, .op
  );

  ahf_dp #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .TOP_ORDER(TOP_ORDER),
    .CHUNK_BITS(CHUNK_BITS)
  ) u_dp (
    .clk, .rst_n, .op, .st, .in_valid, .in_symbol,
    .out_valid, .out_stall, .out_code_bits, .out_bit_count,
    .out_is_new, .out_weight_full, .out_last
  );

endmodule

@@ rtl/ahf_checker.sv @@
// Port-level checks for the FGK coder, attached to the top level by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module ahf_checker #(
  parameter int CHUNK_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_symbol,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_code_bits,
  input logic [5:0]  out_bit_count,
  input logic        out_is_new,
  input logic        out_weight_full,
  input logic        out_last
);

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  a_no_accept_mid_code: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && !out_last))
    else $error("symbol transfer while a code is still in flight");

  a_full_chunks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_bit_count == 6'(CHUNK_BITS)))
    else $error("non-final chunk is not full");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_code_bits) &&
      $stable(out_bit_count) && $stable(out_last) && $stable(out_is_new) &&
      $stable(out_weight_full))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> $stable(in_symbol))
    else $error("stalled symbol changed");

endmodule

bind adaptive_huffman_fgk_coder ahf_checker #(.CHUNK_BITS(CHUNK_BITS)) u_chk (.*);

@@ sim/adaptive_huffman_fgk_coder_tb.sv @@
// Self-checking testbench for the adaptive Huffman (FGK) coder.
// Needs ahf_pkg and the adaptive_huffman_fgk_coder RTL. An internal FGK tree tracks the
// expected code chunks. The run applies a directed table, then skewed random symbols.
`timescale 1ns / 1ps
module adaptive_huffman_fgk_coder_tb;
  import ahf_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] cnt;
    logic               is_new;
    logic               full;
    logic               last;
  } chunk_t;

  typedef struct {
    logic [SYM_W-1:0] sym;
    bit               typed;
    chunk_t           lit;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SYM_W-1:0]   in_symbol = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CODE_W-1:0]  out_code_bits;
  logic [COUNT_W-1:0] out_bit_count;
  logic               out_is_new;
  logic               out_weight_full;
  logic               out_last;

  adaptive_huffman_fgk_coder dut (.*);

  // tree copy
  logic [8:0]  t_par[512];
  logic [8:0]  t_left[512];
  logic [8:0]  t_right[512];
  logic [31:0] t_wt[512];
  logic [9:0]  t_ord[512];
  logic [9:0]  sym_leaf[256];
  logic [8:0]  nyt;
  int          used;

  chunk_t code_q[$];
  int     errors = 0;
  int     sent = 0;
  int     chunks_seen = 0;
  int     new_seen = 0;
  int     multi_seen = 0;
  int     mode = 0;

  function automatic void tree_clear();
    for (int i = 0; i < 512; i++) begin
      t_par[i] = '0; t_left[i] = '0; t_right[i] = '0; t_wt[i] = '0; t_ord[i] = '0;
    end
    for (int i = 0; i < 256; i++) sym_leaf[i] = '0;
    t_ord[0] = 10'd512;
    nyt = '0;
    used = 1;
  endfunction

  function automatic void tree_swap(int a, int b);
    int pa, pb;
    logic [9:0] t;
    pa = t_par[a];
    pb = t_par[b];
    if (pa == pb) begin
      t_left[pa] = t_right[pa];
      t_right[pa] = 9'(a == t_left[pa] ? b : a);
      t_left[pa] = 9'(t_right[pa] == a ? b : a);
    end else begin
      if (t_left[pa] == a) t_left[pa] = 9'(b);
      else t_right[pa] = 9'(b);
      if (t_left[pb] == b) t_left[pb] = 9'(a);
      else t_right[pb] = 9'(a);
      t_par[a] = 9'(pb);
      t_par[b] = 9'(pa);
    end
    t = t_ord[a];
    t_ord[a] = t_ord[b];
    t_ord[b] = t;
  endfunction

  function automatic void tree_climb(int start);
    bit anc[512];
    int n, p, best;
    bit found;
    n = start;
    forever begin
      if (n != 0) begin
        anc = '{default: 1'b0};
        p = n;
        while (p != 0) begin
          p = t_par[p];
          anc[p] = 1'b1;
        end
        found = 1'b0;
        best = 0;
        for (int i = 0; i < used && i < 512; i++) begin
          if (i == n || anc[i]) continue;
          if (t_wt[i] != t_wt[n] || t_ord[i] <= t_ord[n]) continue;
          if (!found || t_ord[i] > t_ord[best]) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) tree_swap(n, best);
      end
      t_wt[n] = t_wt[n] + 1;
      if (n == 0) break;
      n = t_par[n];
    end
  endfunction

  // push the chunks for one symbol, then update the tree
  function automatic void encode_symbol(logic [SYM_W-1:0] s);
    bit   bits[512];
    int   len, n, pos, cnt, nn, lf;
    bit   present, full;
    chunk_t c;
    present = sym_leaf[s][9];
    full = (t_wt[0] == 32'hFFFF_FFFF);
    n = present ? int'(sym_leaf[s][8:0]) : int'(nyt);
    len = 0;
    while (n != 0 && len < 512) begin
      bits[len++] = (t_left[t_par[n]] == n) ? 1'b0 : 1'b1;
      n = t_par[n];
    end
    pos = 0;
    do begin
      c = '0;
      cnt = 0;
      while (cnt < 32 && pos < len) begin
        c.code = {c.code[CODE_W-2:0], bits[len-1-pos]};
        pos++;
        cnt++;
      end
      c.cnt = COUNT_W'(cnt);
      c.is_new = !present;
      c.full = full;
      c.last = (pos >= len);
      code_q.push_back(c);
    end while (pos < len);
    if (full) return;
    if (present) begin
      tree_climb(sym_leaf[s][8:0]);
    end else begin
      if (used + 2 > 512 || t_ord[nyt] < 2) return;
      nn = used;
      lf = used + 1;
      t_par[nn] = nyt;
      t_par[lf] = nyt;
      t_wt[nn] = '0;
      t_wt[lf] = 32'd1;
      t_ord[nn] = t_ord[nyt] - 10'd2;
      t_ord[lf] = t_ord[nyt] - 10'd1;
      t_left[nyt] = 9'(nn);
      t_right[nyt] = 9'(lf);
      sym_leaf[s] = {1'b1, 9'(lf)};
      n = nyt;
      nyt = 9'(nn);
      used += 2;
      tree_climb(n);
    end
  endfunction

  task automatic send_symbol(input logic [SYM_W-1:0] s, input bit typed, input chunk_t lit);
    int gap_pct;
    gap_pct = (mode == 0) ? 23 : (mode == 1) ? 69 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_symbol <= s;
    do @(posedge clk); while (in_stall);
    encode_symbol(s);
    if (typed) begin
      void'(code_q.pop_back());
      code_q.push_back(lit);
    end
    sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("timeout at %0t", $time);
    $display("adaptive_huffman_fgk_coder_tb: FAIL");
    $finish;
  end

  // receiver: stall and check
  always @(posedge clk) begin
    int stall_pct;
    chunk_t got, want;
    stall_pct = (mode == 0) ? 69 : (mode == 1) ? 23 : 0;
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_code_bits, out_bit_count, out_is_new, out_weight_full, out_last};
      chunks_seen++;
      if (got.is_new) new_seen++;
      if (!got.last) multi_seen++;
      if (code_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = code_q.pop_front();
        if (got.code !== want.code)
          $display("%0t: code_bits expected %h actual %h", $time, want.code, got.code);
        if (got.cnt !== want.cnt)
          $display("%0t: bit_count expected %0d actual %0d", $time, want.cnt, got.cnt);
        if (got.is_new !== want.is_new)
          $display("%0t: is_new expected %b actual %b", $time, want.is_new, got.is_new);
        if (got.full !== want.full)
          $display("%0t: weight_full expected %b actual %b", $time, want.full, got.full);
        if (got.last !== want.last)
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  row_t dir[$];
  logic [SYM_W-1:0] hot[24];

  initial begin
    chunk_t none;
    int k;
    none = '0;
    tree_clear();
    // empty root code, then NYT on the left, then first leaf on the right
    dir.push_back('{8'h41, 1'b1, '{32'd0, 6'd0, 1'b1, 1'b0, 1'b1}});
    dir.push_back('{8'h00, 1'b1, '{32'd0, 6'd1, 1'b1, 1'b0, 1'b1}});
    dir.push_back('{8'h41, 1'b1, '{32'd1, 6'd1, 1'b0, 1'b0, 1'b1}});
    begin
      logic [SYM_W-1:0] rest[];
      rest = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h0F,
               8'hF0, 8'h00, 8'h41, 8'h80, 8'h01, 8'h7F, 8'hFE,
               8'h55, 8'hAA, 8'h55, 8'hFF, 8'h41, 8'h41};
      foreach (rest[i]) dir.push_back('{rest[i], 1'b0, none});
    end
    foreach (hot[i]) hot[i] = 8'($urandom_range(255));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) send_symbol(dir[i].sym, dir[i].typed, dir[i].lit);

    // hold until the directed results have drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (code_q.size() != 0) @(posedge clk);

    for (int i = 0; i < 267; i++) begin
      if (i == 80) mode = 1;
      if (i == 175) mode = 2;
      if ($urandom_range(99) < 6)
        send_symbol(8'($urandom_range(255)), 1'b0, none);
      else begin
        // skew toward the first few entries so weights diverge
        k = $urandom_range(3) == 0 ? $urandom_range(23) : $urandom_range(5);
        send_symbol(hot[k], 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (code_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (code_q.size() != 0) begin
      $display("%0t: %0d expected chunks never arrived", $time, code_q.size());
      errors++;
    end
    $display("Sent %0d symbols (%0d tree nodes), checked %0d chunks, %0d NYT, %0d non-final.",
             sent, used, chunks_seen, new_seen, multi_seen);
    if (errors == 0)
      $display("adaptive_huffman_fgk_coder_tb: PASS");
    else
      $display("adaptive_huffman_fgk_coder_tb: FAIL");
    $finish;
  end

endmodule
